// ===== rtl/rjdf_pkg.sv =====
// Shared types and constants of the right-justified decimal formatter.
package rjdf_pkg;

    localparam int MAX_FIELD = 16;
    localparam int VAL_W     = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int CHAR_W    = 8;
    localparam int FW_W      = 5;
    localparam int POS_W     = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
    localparam int CMP_W     = (FW_W > POS_W + 1) ? FW_W : POS_W + 1;
    localparam int STEP_W    = $clog2(VAL_W);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAD_CHAR    = 2'd1;
    localparam logic [IDX_W-1:0] REG_GROUP_CHAR  = 2'd2;

    localparam logic [FW_W-1:0]   FIELD_WIDTH_RST = 5'd8;
    localparam logic [CHAR_W-1:0] PAD_CHAR_RST    = 8'd32;
    localparam logic [CHAR_W-1:0] GROUP_CHAR_RST  = 8'd0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // One classified request: sign and magnitude.
    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic [FW_W-1:0]   field_width;
        logic [CHAR_W-1:0] pad_char;
        logic [CHAR_W-1:0] group_char;
    } t_cfg;

endpackage

// ===== rtl/rjdf_front.sv =====
// Input stage: accepts a request and splits it into sign and magnitude.
module rjdf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rjdf_pkg::VAL_W-1:0]  i_value,
    output logic                        o_push,
    output rjdf_pkg::t_item             o_item,
    input  logic                        i_q_ready
);

    logic            r_valid;
    rjdf_pkg::t_item r_item;
    rjdf_pkg::t_item n_item;

    always_comb begin
        n_item.neg = i_value[rjdf_pkg::VAL_W-1];
        // Two's complement negation; the most negative value maps to 2^31.
        n_item.mag = n_item.neg ? (~i_value + 1'b1) : i_value;
    end

    assign o_stall = r_valid && !i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/rjdf_queue.sv =====
// Short queue between the input stage and the conversion engine.
module rjdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rjdf_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output rjdf_pkg::t_item o_item
);

    rjdf_pkg::t_item                 r_mem [rjdf_pkg::QDEPTH];
    logic [rjdf_pkg::QPTR_W-1:0]     r_wp;
    logic [rjdf_pkg::QPTR_W-1:0]     r_rp;
    logic [rjdf_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_ready = r_cnt != rjdf_pkg::QCNT_W'(rjdf_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == rjdf_pkg::QPTR_W'(rjdf_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == rjdf_pkg::QPTR_W'(rjdf_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/rjdf_back.sv =====
// Conversion engine: binary to BCD, field fill from the right, serial output.
module rjdf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rjdf_pkg::t_cfg               i_cfg,
    input  logic                         i_q_valid,
    input  rjdf_pkg::t_item              i_q_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rjdf_pkg::CHAR_W-1:0]  o_text_char,
    output logic                         o_is_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [1:0] PH_DIGIT = 2'd0;
    localparam logic [1:0] PH_SEP   = 2'd1;
    localparam logic [1:0] PH_TAIL  = 2'd2;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [1:0]                        r_phase;
    logic [1:0]                        n_phase;
    logic [rjdf_pkg::STEP_W-1:0]       r_step;
    logic [rjdf_pkg::VAL_W-1:0]        r_bin;
    logic [rjdf_pkg::BCD_W-1:0]        r_bcd;
    logic [rjdf_pkg::BCD_W-1:0]        n_bcd;
    logic [rjdf_pkg::BCD_W-1:0]        bcd_adj;
    logic                              r_neg;
    logic                              r_sign_done;
    logic                              n_sign_done;
    logic [1:0]                        r_grp;
    logic [1:0]                        n_grp;
    logic [rjdf_pkg::POS_W-1:0]        r_pos;
    logic [rjdf_pkg::POS_W-1:0]        r_k;
    logic [rjdf_pkg::CHAR_W-1:0]       r_field [rjdf_pkg::MAX_FIELD];
    logic [rjdf_pkg::CHAR_W-1:0]       fill_char;
    logic [rjdf_pkg::CMP_W-1:0]        fw_ext;
    logic [rjdf_pkg::POS_W-1:0]        w_m1;
    logic                              more;
    logic                              out_free;
    logic                              r_out_valid;
    logic [rjdf_pkg::CHAR_W-1:0]       r_out_char;
    logic                              r_out_last;

    // Last position of the field after clamping the width to 1..MAX_FIELD.
    always_comb begin
        fw_ext = (rjdf_pkg::CMP_W)'(i_cfg.field_width);
        if (fw_ext == '0) begin
            w_m1 = '0;
        end else if (fw_ext > (rjdf_pkg::CMP_W)'(rjdf_pkg::MAX_FIELD)) begin
            w_m1 = (rjdf_pkg::POS_W)'(rjdf_pkg::MAX_FIELD - 1);
        end else begin
            w_m1 = (rjdf_pkg::POS_W)'(fw_ext - 1'b1);
        end
    end

    // One double-dabble step: correct each digit, then shift in the next bit.
    always_comb begin
        for (int i = 0; i < rjdf_pkg::DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    assign more = (r_bcd >> 4) != '0;

    always_comb begin
        fill_char   = i_cfg.pad_char;
        n_phase     = r_phase;
        n_grp       = r_grp;
        n_sign_done = r_sign_done;
        unique case (r_phase)
            PH_DIGIT: begin
                fill_char = rjdf_pkg::CHAR_ZERO + {4'd0, r_bcd[3:0]};
                n_grp     = (r_grp == 2'd2) ? 2'd0 : r_grp + 2'd1;
                if (!more) begin
                    n_phase = PH_TAIL;
                end else if (i_cfg.group_char != '0 && r_grp == 2'd2) begin
                    n_phase = PH_SEP;
                end
            end
            PH_SEP: begin
                fill_char = i_cfg.group_char;
                n_phase   = PH_DIGIT;
            end
            PH_TAIL: begin
                if (r_neg && !r_sign_done) begin
                    fill_char   = rjdf_pkg::CHAR_MINUS;
                    n_sign_done = 1'b1;
                end
            end
            default: begin
                fill_char = i_cfg.pad_char;
            end
        endcase
    end

    always_comb begin
        n_bcd = r_bcd;
        if (r_state == ST_IDLE) begin
            n_bcd = '0;
        end else if (r_state == ST_CONV) begin
            n_bcd = {bcd_adj[rjdf_pkg::BCD_W-2:0], r_bin[rjdf_pkg::VAL_W-1]};
        end else if (r_state == ST_FILL && r_phase == PH_DIGIT) begin
            n_bcd = r_bcd >> 4;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_CONV;
            ST_CONV: if (r_step == '1) n_state = ST_FILL;
            ST_FILL: if (r_pos == '0) n_state = ST_EMIT;
            ST_EMIT: if (out_free && r_k == w_m1) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        unique case (r_state)
            ST_IDLE: begin
                r_bin       <= i_q_item.mag;
                r_neg       <= i_q_item.neg;
                r_step      <= '0;
            end
            ST_CONV: begin
                r_bin       <= r_bin << 1;
                r_step      <= r_step + 1'b1;
                r_pos       <= w_m1;
                r_phase     <= PH_DIGIT;
                r_grp       <= 2'd0;
                r_sign_done <= 1'b0;
            end
            ST_FILL: begin
                r_field[r_pos] <= fill_char;
                r_pos          <= r_pos - 1'b1;
                r_phase        <= n_phase;
                r_grp          <= n_grp;
                r_sign_done    <= n_sign_done;
                r_k            <= '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out_char <= r_field[r_k];
                    r_out_last <= r_k == w_m1;
                    r_k        <= r_k + 1'b1;
                end
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_is_last   = r_out_last;

endmodule

// ===== rtl/right_justified_decimal_formatter.sv =====
// Top level of the right-justified decimal formatter.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   input    | i_valid / o_stall     | i_value (signed 32 bits)
//   output   | o_valid / i_stall     | o_text_char, o_is_last
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request leaves the queue, runs through a bit-serial binary-to-BCD
// conversion, then fills the field buffer one character at a time from the
// right and sends the field one character at a time; the serial conversion
// loop and the one write port of the field buffer set this pace.
// Two requests can wait in the queue while one is converted.
// Reset is synchronous and clears the queue, the engine and the registers.
// A stall on the output holds the character; the next request is taken from
// the queue once the last character of the field has been loaded.
module right_justified_decimal_formatter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [rjdf_pkg::VAL_W-1:0]   i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rjdf_pkg::CHAR_W-1:0]  o_text_char,
    output logic                         o_is_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rjdf_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [rjdf_pkg::CHAR_W-1:0]  i_cfg_data
);

    rjdf_pkg::t_cfg  r_cfg;
    rjdf_pkg::t_item front_item;
    rjdf_pkg::t_item q_item;
    logic            front_push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_width <= rjdf_pkg::FIELD_WIDTH_RST;
            r_cfg.pad_char    <= rjdf_pkg::PAD_CHAR_RST;
            r_cfg.group_char  <= rjdf_pkg::GROUP_CHAR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rjdf_pkg::REG_FIELD_WIDTH: r_cfg.field_width <= i_cfg_data[rjdf_pkg::FW_W-1:0];
                rjdf_pkg::REG_PAD_CHAR:    r_cfg.pad_char    <= i_cfg_data;
                rjdf_pkg::REG_GROUP_CHAR:  r_cfg.group_char  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rjdf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .o_push    (front_push),
        .o_item    (front_item),
        .i_q_ready (q_ready)
    );

    rjdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rjdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_is_last   (o_is_last)
    );

endmodule

// ===== rtl/rjdf_checker.sv =====
// Port-level checks for the right-justified decimal formatter, with its bind.
module rjdf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [rjdf_pkg::CHAR_W-1:0]  o_text_char,
    input logic                         o_is_last,
    input logic                         o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_text_char) && $stable(o_is_last))
        else $error("output character changed while stalled");

    // A new field needs a full conversion, so no character follows the last one directly.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_is_last |=> !o_valid)
        else $error("character sent right after the end of a field");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind right_justified_decimal_formatter rjdf_checker u_rjdf_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the right-justified decimal formatter.
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 52;
    localparam int PRESSURE_ITEMS = 24;
    localparam int N_DIRECTED     = 30;

    // Index 3 is decoded by nothing; writing it must leave the format alone.
    localparam logic [rjdf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [rjdf_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_char;

    // Typed rows carry their expected field right-aligned in text.
    typedef struct packed {
        t_row_kind                         kind;
        logic [rjdf_pkg::IDX_W-1:0]        idx;
        logic [rjdf_pkg::CHAR_W-1:0]       data;
        logic [rjdf_pkg::VAL_W-1:0]        value;
        bit                                typed;
        logic [8*rjdf_pkg::MAX_FIELD-1:0]  text;
    } t_stim_row;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic [rjdf_pkg::VAL_W-1:0]    i_value     = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic [rjdf_pkg::CHAR_W-1:0]   o_text_char;
    logic                          o_is_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rjdf_pkg::IDX_W-1:0]    i_cfg_index = '0;
    logic [rjdf_pkg::CHAR_W-1:0]   i_cfg_data  = '0;

    logic                hold_rx      = 1'b0;
    int                  rx_stall_pct = 0;
    int                  gap_pct      = 0;

    logic [rjdf_pkg::FW_W-1:0]     cfg_width = rjdf_pkg::FIELD_WIDTH_RST;
    logic [rjdf_pkg::CHAR_W-1:0]   cfg_pad   = rjdf_pkg::PAD_CHAR_RST;
    logic [rjdf_pkg::CHAR_W-1:0]   cfg_group = rjdf_pkg::GROUP_CHAR_RST;

    t_text_char          pending_chars [$];
    t_text_char          due;
    int                  error_count   = 0;
    int                  chars_checked = 0;
    int                  requests_sent = 0;
    int                  reg_writes    = 0;
    int                  quiet_cycles  = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd0,         1'b1, "       0"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd12345,     1'b1, "   12345"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd1,       1'b1, "      -1"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h7FFF_FFFF, 1'b1, "47483647"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h8000_0000, 1'b1, "47483648"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd1234567, 1'b1, "-1234567"},
        '{ROW_CFG,  rjdf_pkg::REG_FIELD_WIDTH, 8'd16, 32'd0,         1'b0, '0},
        '{ROW_CFG,  rjdf_pkg::REG_PAD_CHAR,    8'h2A, 32'd0,         1'b0, '0},
        '{ROW_CFG,  rjdf_pkg::REG_GROUP_CHAR,  8'h2C, 32'd0,         1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h8000_0000, 1'b1, "**-2,147,483,648"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h7FFF_FFFF, 1'b1, "***2,147,483,647"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd1000,      1'b1, "***********1,000"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd999,       1'b1, "*************999"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd100000,  1'b1, "********-100,000"},
        '{ROW_CFG,  rjdf_pkg::REG_FIELD_WIDTH, 8'd0,  32'd0,         1'b0, '0},
        '{ROW_CFG,  rjdf_pkg::REG_PAD_CHAR,    8'h00, 32'd0,         1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd7,         1'b1, "7"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd9,       1'b1, "9"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h8000_0000, 1'b1, "8"},
        '{ROW_CFG,  rjdf_pkg::REG_FIELD_WIDTH, 8'd4,  32'd0,         1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd1234,      1'b1, ",234"},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd123,     1'b1, "-123"},
        '{ROW_CFG,  rjdf_pkg::REG_FIELD_WIDTH, 8'hE5, 32'd0,         1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd1234,    1'b0, '0},
        '{ROW_CFG,  rjdf_pkg::REG_FIELD_WIDTH, 8'h1F, 32'd0,         1'b0, '0},
        '{ROW_CFG,  rjdf_pkg::REG_GROUP_CHAR,  8'hFF, 32'd0,         1'b0, '0},
        '{ROW_CFG,  REG_UNUSED,                8'hFF, 32'd0,         1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, -32'sd5,       1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'd1234567,   1'b0, '0},
        '{ROW_ITEM, rjdf_pkg::REG_FIELD_WIDTH, 8'h00, 32'h7FFF_FFFF, 1'b0, '0}
    };

    right_justified_decimal_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_is_last   (o_is_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Width register is 5 bits; zero and values above the field size saturate.
    function automatic int field_len();
        int w;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > rjdf_pkg::MAX_FIELD) w = rjdf_pkg::MAX_FIELD;
        return w;
    endfunction

    function automatic void push_char(input logic [rjdf_pkg::CHAR_W-1:0] ch, input logic last);
        t_text_char entry;
        entry.ch   = ch;
        entry.last = last;
        pending_chars.push_back(entry);
    endfunction

    function automatic void queue_typed_text(input logic [8*rjdf_pkg::MAX_FIELD-1:0] text);
        int w;
        int k;
        w = field_len();
        for (k = 0; k < w; k++)
            push_char(text[8*(w-1-k) +: 8], k == w - 1);
    endfunction

    // Builds the field from the right: digits, separators, sign, then padding.
    function automatic void format_value(input logic [rjdf_pkg::VAL_W-1:0] raw);
        logic [rjdf_pkg::CHAR_W-1:0] chars [rjdf_pkg::MAX_FIELD];
        logic [rjdf_pkg::VAL_W-1:0]  mag;
        int                          w;
        int                          pos;
        int                          ndig;
        int                          k;
        w    = field_len();
        mag  = raw[rjdf_pkg::VAL_W-1] ? (32'd0 - raw) : raw;
        pos  = w - 1;
        ndig = 0;
        do begin
            chars[pos] = rjdf_pkg::CHAR_ZERO + 8'(mag % 10);
            pos--;
            mag = mag / 10;
            ndig++;
            if (cfg_group != 8'd0 && ndig % 3 == 0 && mag != 0 && pos >= 0) begin
                chars[pos] = cfg_group;
                pos--;
            end
        end while (mag != 0 && pos >= 0);
        if (raw[rjdf_pkg::VAL_W-1] && pos >= 0) begin
            chars[pos] = rjdf_pkg::CHAR_MINUS;
            pos--;
        end
        while (pos >= 0) begin
            chars[pos] = cfg_pad;
            pos--;
        end
        for (k = 0; k < w; k++)
            push_char(chars[k], k == w - 1);
    endfunction

    // Mostly values of a random digit count, so short and long fields both occur.
    function automatic logic [rjdf_pkg::VAL_W-1:0] draw_value();
        logic [rjdf_pkg::VAL_W-1:0] span;
        logic [rjdf_pkg::VAL_W-1:0] v;
        int                         ndig;
        case ($urandom_range(19))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'd0;
            3, 4, 5, 6: v = $urandom();
            default: begin
                ndig = $urandom_range(1, 9);
                span = 32'd1;
                repeat (ndig) span = span * 10;
                v = $urandom() % span;
                if ($urandom_range(1) == 1) v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct = 0;
                rx_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                gap_pct = 62;
                rx_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                gap_pct = 0;
                rx_stall_pct <= 62;
            end
            default: begin
                gap_pct = 23;
                rx_stall_pct <= 23;
            end
        endcase
    endtask

    task automatic send_request(input logic [rjdf_pkg::VAL_W-1:0] v, input bit typed,
                                input logic [8*rjdf_pkg::MAX_FIELD-1:0] text);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        if (typed)
            queue_typed_text(text);
        else
            format_value(v);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Leaves the write request raised; the caller lowers it after the last write.
    task automatic write_reg(input logic [rjdf_pkg::IDX_W-1:0] idx,
                             input logic [rjdf_pkg::CHAR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            rjdf_pkg::REG_FIELD_WIDTH: cfg_width = data[rjdf_pkg::FW_W-1:0];
            rjdf_pkg::REG_PAD_CHAR:    cfg_pad   = data;
            rjdf_pkg::REG_GROUP_CHAR:  cfg_group = data;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(input logic [rjdf_pkg::CHAR_W-1:0] fw,
                              input logic [rjdf_pkg::CHAR_W-1:0] pad,
                              input logic [rjdf_pkg::CHAR_W-1:0] grp);
        drain_results();
        write_reg(rjdf_pkg::REG_FIELD_WIDTH, fw);
        write_reg(rjdf_pkg::REG_PAD_CHAR, pad);
        write_reg(rjdf_pkg::REG_GROUP_CHAR, grp);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected character %h (last %b) at %0t",
                                 o_text_char, o_is_last, $time);
                end else begin
                    due = pending_chars.pop_front();
                    chars_checked++;
                    if (o_text_char !== due.ch || o_is_last !== due.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch at %0t: expected char %h last %b, got %h last %b",
                                     $time, due.ch, due.last, o_text_char, o_is_last);
                    end
                end
            end
            i_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or character moved for %0d cycles", quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                          r;
        int                          phase;
        int                          n;
        bit                          prev_cfg;
        logic [rjdf_pkg::CHAR_W-1:0] fw;
        logic [rjdf_pkg::CHAR_W-1:0] pad;
        logic [rjdf_pkg::CHAR_W-1:0] grp;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        prev_cfg = 1'b0;
        for (r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (!prev_cfg) drain_results();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
                prev_cfg = 1'b1;
            end else begin
                i_cfg_valid <= 1'b0;
                send_request(directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].text);
                prev_cfg = 1'b0;
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0, 7: fw = 8'd16;
                1: fw = 8'd1;
                2: fw = 8'd31;
                3: fw = 8'd0;
                5: fw = 8'($urandom_range(255));
                default: fw = 8'($urandom_range(1, rjdf_pkg::MAX_FIELD));
            endcase
            pad = (phase % 2 == 1) ? 8'($urandom_range(255)) : 8'h20;
            if (phase % 3 == 0)
                grp = 8'h00;
            else if ($urandom_range(1) == 1)
                grp = 8'h2C;
            else
                grp = 8'($urandom_range(1, 255));
            set_format(fw, pad, grp);
            set_idling(t_idle_mode'(phase % 4));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(draw_value(), 1'b0, '0);
        end

        // Hold the output long enough that the request queue fills and stalls the input.
        set_format(8'd16, 8'h20, 8'h2C);
        set_idling(IDLE_NONE);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            begin
                for (n = 0; n < PRESSURE_ITEMS; n++)
                    send_request(draw_value(), 1'b0, '0);
            end
        join
        i_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Formatted %0d requests into %0d checked characters over %0d register writes,",
                 requests_sent, chars_checked, reg_writes);
        $display("with widths from saturated low to saturated high and a long output hold-off.");
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d failures, %0d characters still expected", error_count,
                     pending_chars.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rjdf_pkg.sv
rtl/rjdf_front.sv
rtl/rjdf_queue.sv
rtl/rjdf_back.sv
rtl/right_justified_decimal_formatter.sv
rtl/rjdf_checker.sv
dv/testbench.sv
